/* design/soc_pkg.sv */
`default_nettype none

package soc_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int COUNT_MAX   = 1024;
	localparam int CNT_W       = $clog2(COUNT_MAX + 1);
	localparam int ACT_W       = 2;
	localparam int CHAR_W      = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_PATTERN = 2'd1,
		ACT_TEXT    = 2'd2
	} action_t;

	// Strobes broadcast to every cell of the row.
	typedef struct packed {
		logic clear;
		logic push_pat;
		logic push_text;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* design/soc_in_if.sv */
`default_nettype none

interface soc_in_if;
	logic                       valid;
	logic                       ready;
	logic [soc_pkg::ACT_W-1:0]  action;
	logic [soc_pkg::CHAR_W-1:0] char_value;

	modport source (output valid, action, char_value, input ready);
	modport sink (input valid, action, char_value, output ready);
endinterface

`default_nettype wire

/* design/soc_out_if.sv */
`default_nettype none

interface soc_out_if;
	logic                      valid;
	logic                      ready;
	logic                      match_end;
	logic [soc_pkg::CNT_W-1:0] match_count;
	logic                      pattern_overflow;

	modport source (output valid, match_end, match_count, pattern_overflow, input ready);
	modport sink (input valid, match_end, match_count, pattern_overflow, output ready);
endinterface

`default_nettype wire

/* design/soc_cell.sv */
`default_nettype none

// One window position: holds a pattern byte (newest byte in cell 0) and a
// text byte, and compares the text byte arriving from its left neighbor.
module soc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  soc_pkg::cell_ctl_t         ctl,
	input  logic [soc_pkg::CHAR_W-1:0] pat_in,
	input  logic                       occ_in,
	input  logic [soc_pkg::CHAR_W-1:0] text_in,
	input  logic                       text_vld_in,
	output logic [soc_pkg::CHAR_W-1:0] pat_q,
	output logic                       occ_q,
	output logic [soc_pkg::CHAR_W-1:0] text_q,
	output logic                       text_vld_q,
	output logic                       ok
);

	// An empty cell never blocks a match; an occupied one needs a seen, equal byte.
	assign ok = !occ_q || (text_vld_in && (pat_q == text_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= 1'b0;
			text_vld_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q      <= 1'b0;
			text_vld_q <= 1'b0;
		end else begin
			if (ctl.push_pat) begin
				occ_q <= occ_in;
			end
			if (ctl.push_text) begin
				text_vld_q <= text_vld_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_pat) begin
			pat_q <= pat_in;
		end
		if (ctl.push_text) begin
			text_q <= text_in;
		end
	end

endmodule

`default_nettype wire

/* design/substring_occurrence_counter.sv */
`default_nettype none

// Counts occurrences of a loaded pattern (up to 64 bytes) in a byte stream,
// overlapping ones included. One command is taken every cycle and its result
// appears in the output register on the next cycle; a new command enters in the
// same cycle that the held result is taken, and input stalls while the sink
// holds a result back. A row of 64 cells holds the
// pattern, newest byte first, next to the last text bytes; all cells compare
// in the same cycle and their verdicts are ANDed into the match flag, so the
// compare across the row plus the 11-bit count update set the cycle time.
// Clear empties pattern, text window, count and overflow flag at once.
module substring_occurrence_counter (
	input  logic       clk,
	input  logic       arst_n,
	soc_in_if.sink     cmd,
	soc_out_if.source  res
);

	localparam int N = soc_pkg::PATTERN_MAX;

	soc_pkg::cell_ctl_t          ctl;
	logic                        in_fire;
	logic                        hit;
	logic                        full;
	logic                        set_ovf;
	logic [N-1:0]                ok_vec;
	logic [N-1:0]                occ_vec;
	logic [N-1:0]                tv_vec;
	logic [soc_pkg::CHAR_W-1:0]  pat_arr  [N];
	logic [soc_pkg::CHAR_W-1:0]  text_arr [N];
	logic                        out_vld_q;
	logic                        match_end_q;
	logic [soc_pkg::CNT_W-1:0]   cnt_q;
	logic                        ovf_q;

	assign cmd.ready = !out_vld_q || res.ready;
	assign in_fire   = cmd.valid && cmd.ready;
	assign full      = occ_vec[N-1];

	always_comb begin
		ctl     = '0;
		set_ovf = 1'b0;
		if (in_fire) begin
			case (cmd.action)
				soc_pkg::ACT_CLEAR: begin
					ctl.clear = 1'b1;
				end
				soc_pkg::ACT_PATTERN: begin
					// drop bytes beyond capacity
					ctl.push_pat = !full;
					set_ovf      = full;
				end
				soc_pkg::ACT_TEXT: begin
					ctl.push_text = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [soc_pkg::CHAR_W-1:0] pat_in;
		logic                       occ_in;
		logic [soc_pkg::CHAR_W-1:0] text_in;
		logic                       text_vld_in;

		if (g == 0) begin : g_head
			assign pat_in      = cmd.char_value;
			assign occ_in      = 1'b1;
			assign text_in     = cmd.char_value;
			assign text_vld_in = 1'b1;
		end else begin : g_link
			assign pat_in      = pat_arr[g-1];
			assign occ_in      = occ_vec[g-1];
			assign text_in     = text_arr[g-1];
			assign text_vld_in = tv_vec[g-1];
		end

		soc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.pat_in      (pat_in),
			.occ_in      (occ_in),
			.text_in     (text_in),
			.text_vld_in (text_vld_in),
			.pat_q       (pat_arr[g]),
			.occ_q       (occ_vec[g]),
			.text_q      (text_arr[g]),
			.text_vld_q  (tv_vec[g]),
			.ok          (ok_vec[g])
		);
	end

	assign hit = ctl.push_text && occ_vec[0] && (&ok_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (hit && (cnt_q < soc_pkg::CNT_W'(soc_pkg::COUNT_MAX))) begin
				cnt_q <= cnt_q + soc_pkg::CNT_W'(1);
			end
			if (set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_fire) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			match_end_q <= hit;
		end
	end

	// Count and flag change only on an accept, so they hold while the result stalls.
	assign res.valid            = out_vld_q;
	assign res.match_end        = match_end_q;
	assign res.match_count      = cnt_q;
	assign res.pattern_overflow = ovf_q;

	a_occ_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec >> 1) & ~occ_vec) == '0)
		else $error("pattern occupancy not contiguous");

	a_tv_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((tv_vec >> 1) & ~tv_vec) == '0)
		else $error("text window valid bits not contiguous");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= soc_pkg::CNT_W'(soc_pkg::COUNT_MAX))
		else $error("count above saturation limit");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (occ_vec == '0) && (tv_vec == '0) && (cnt_q == '0) && !ovf_q)
		else $error("clear left state behind");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (cnt_q == $past(cnt_q) + soc_pkg::CNT_W'(1)) ||
			(cnt_q == soc_pkg::CNT_W'(soc_pkg::COUNT_MAX)))
		else $error("match not counted");

endmodule

`default_nettype wire
